// File: hdl/whole_word_token_replacer_defines.svh
// Assertion helpers used by the datapath RTL file.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef WHOLE_WORD_TOKEN_REPLACER_DEFINES_SVH
`define WHOLE_WORD_TOKEN_REPLACER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WWTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WWTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wwtr_pkg.sv
`timescale 1ns / 1ps
package wwtr_pkg;

  // Token buffer depth in bytes.
  localparam int MAX_WORD = 8;
  localparam int TOK_IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  // Length fields hold 0 to 15, the replacement word always has eight lanes.
  localparam int LEN_W = 4;
  localparam int REPL_BYTES = 8;
  localparam int REPL_IDX_W = 3;
  localparam int WORD_W = 64;
  localparam int HITS_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_WORD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_WORD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_EN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              last;
    logic [HITS_W-1:0] hits;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOKEN,
    ST_TAIL
  } wwtr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic store;
    logic flush;
    logic spill;
    logic emit_tok;
    logic emit_tail;
  } wwtr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_end;
    logic in_ident;
    logic tok_ovf;
    logic tok_full;
    logic tok_live;
    logic emit_done;
    logic out_free;
  } wwtr_status_t;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_UNDERSCORE || c == CH_DOLLAR;
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    return (en && c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
  endfunction

endpackage

// File: hdl/whole_word_token_replacer.sv
`timescale 1ns / 1ps
// After an input word that is not stored is accepted, the controller enters its token or
// tail state and each result is then registered in the output register. A byte stored
// into the token gives no result; any other byte, and each token end or spill, walks out
// the emitted token or replacement bytes, then the byte or end word; out_ready low stalls the walk.
// Reset: synchronous active-low rst_n clears the configuration, token count, hits, output
// valid and the controller; both ready outputs stay low while reset is held.
module whole_word_token_replacer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wwtr_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wwtr_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wwtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wwtr_pkg::WORD_W-1:0]    cfg_data
);
  import wwtr_pkg::*;

  // The controller and the datapath talk only through these two structs.
  wwtr_cmd_t    cmd;
  wwtr_status_t status;

  // Configuration words are taken whenever the block is out of reset. They are
  // expected only while the block is idle, so no interlock with the token path
  // is needed.
  assign cfg_ready = rst_n;

  // The controller accepts an input word only in its idle state. It stores identifier
  // bytes directly while the token has room, passes them on after an overflow, or starts
  // a flush or spill that walks the token or replacement bytes out one word per cycle while
  // the output register is free, then ends with the byte itself or the last-marked end word.
  wwtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the token buffer, the hit counter
  // and the output register. The output register lets the next input word be
  // accepted while a finished result still waits for the consumer.
  wwtr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/wwtr_ctrl.sv
`timescale 1ns / 1ps
module wwtr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wwtr_pkg::wwtr_status_t status,
  output wwtr_pkg::wwtr_cmd_t    cmd
);
  import wwtr_pkg::*;

  wwtr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          priority if (status.in_end || !status.in_ident) begin
            cmd.capture = 1'b1;
            cmd.flush = 1'b1;
            state_nxt = status.tok_live ? ST_TOKEN : ST_TAIL;
          end else if (status.tok_ovf) begin
            cmd.capture = 1'b1;
            state_nxt = ST_TAIL;
          end else if (!status.tok_full) begin
            cmd.store = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cmd.spill = 1'b1;
            state_nxt = ST_TOKEN;
          end
        end
      end
      ST_TOKEN: begin
        if (status.emit_done) begin
          state_nxt = ST_TAIL;
        end else if (status.out_free) begin
          cmd.emit_tok = 1'b1;
        end
      end
      ST_TAIL: begin
        if (status.out_free) begin
          cmd.emit_tail = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/wwtr_datapath.sv
`timescale 1ns / 1ps
`include "whole_word_token_replacer_defines.svh"
module wwtr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wwtr_pkg::in_word_t                 in_data,
  input  logic                               cfg_we,
  input  logic [wwtr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wwtr_pkg::WORD_W-1:0]        cfg_data,
  input  wwtr_pkg::wwtr_cmd_t                cmd,
  output wwtr_pkg::wwtr_status_t             status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wwtr_pkg::out_word_t                out_data
);
  import wwtr_pkg::*;

  logic [WORD_W-1:0] search_word_r, replace_word_r;
  logic [LEN_W-1:0]  search_len_r, replace_len_r;
  logic              replace_en_r, fold_case_r;

  logic [7:0]        tok_store_r [MAX_WORD];
  logic [LEN_W-1:0]  tok_cnt_r;
  logic              tok_ovf_r;
  logic [HITS_W-1:0] hits_r;

  logic [7:0]        cur_byte_r;
  logic              cur_end_r;
  logic              emit_repl_r;
  logic [LEN_W-1:0]  emit_len_r, emit_idx_r;
  logic              out_valid_r;
  out_word_t         out_r;

  logic [7:0]        in_fold;
  logic              in_end;
  logic              tok_live, tok_full, bytes_eq, match, substitute, emit_done;
  logic [LEN_W-1:0]  repl_n;
  logic [7:0]        emit_byte;

  assign in_fold = fold_byte(in_data.in_byte, fold_case_r);
  assign in_end = in_data.end_of_text || (in_data.in_byte == CH_NUL);
  assign tok_live = !tok_ovf_r && (tok_cnt_r != '0);
  assign tok_full = (tok_cnt_r == LEN_W'(MAX_WORD));
  assign repl_n = (replace_len_r > LEN_W'(REPL_BYTES)) ? LEN_W'(REPL_BYTES) : replace_len_r;
  assign emit_done = (emit_idx_r == emit_len_r);

  // Byte compare over the stored part of the token only.
  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < MAX_WORD; i++) begin
      if ((LEN_W'(i) < tok_cnt_r) && (tok_store_r[i] != search_word_r[8*i +: 8])) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign match = tok_live && (search_len_r != '0) &&
                 (search_len_r <= LEN_W'(MAX_WORD)) &&
                 (tok_cnt_r == search_len_r) && bytes_eq;
  assign substitute = match && replace_en_r;

  assign emit_byte = emit_repl_r ?
                     replace_word_r[8*emit_idx_r[REPL_IDX_W-1:0] +: 8] :
                     tok_store_r[emit_idx_r[TOK_IDX_W-1:0]];

  assign status.in_end = in_end;
  assign status.in_ident = is_ident(in_data.in_byte);
  assign status.tok_ovf = tok_ovf_r;
  assign status.tok_full = tok_full;
  assign status.tok_live = tok_live;
  assign status.emit_done = emit_done;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      tok_store_r[tok_cnt_r[TOK_IDX_W-1:0]] <= in_fold;
    end
    if (cmd.capture) begin
      cur_byte_r <= in_fold;
      cur_end_r <= in_end;
    end
    if (cmd.emit_tok) begin
      out_r <= '{out_byte: emit_byte, byte_valid: 1'b1, last: 1'b0, hits: hits_r};
    end else if (cmd.emit_tail) begin
      out_r <= '{out_byte: cur_end_r ? CH_NUL : cur_byte_r, byte_valid: !cur_end_r,
                 last: cur_end_r, hits: hits_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_word_r <= '0;
      search_len_r <= '0;
      replace_word_r <= '0;
      replace_len_r <= '0;
      replace_en_r <= 1'b0;
      fold_case_r <= 1'b0;
      tok_cnt_r <= '0;
      tok_ovf_r <= 1'b0;
      hits_r <= '0;
      emit_repl_r <= 1'b0;
      emit_len_r <= '0;
      emit_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEARCH_WORD:  search_word_r <= cfg_data;
          CFG_SEARCH_LEN:   search_len_r <= cfg_data[LEN_W-1:0];
          CFG_REPLACE_WORD: replace_word_r <= cfg_data;
          CFG_REPLACE_LEN:  replace_len_r <= cfg_data[LEN_W-1:0];
          CFG_REPLACE_EN:   replace_en_r <= cfg_data[0];
          CFG_FOLD_CASE:    fold_case_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.store) begin
        tok_cnt_r <= tok_cnt_r + LEN_W'(1);
      end
      if (cmd.flush) begin
        if (match && (hits_r != '1)) begin
          hits_r <= hits_r + HITS_W'(1);
        end
        emit_repl_r <= substitute;
        emit_len_r <= substitute ? repl_n : (tok_live ? tok_cnt_r : '0);
        emit_idx_r <= '0;
        tok_cnt_r <= '0;
        tok_ovf_r <= 1'b0;
      end
      if (cmd.spill) begin
        emit_repl_r <= 1'b0;
        emit_len_r <= tok_cnt_r;
        emit_idx_r <= '0;
        tok_cnt_r <= '0;
        tok_ovf_r <= 1'b1;
      end
      if (cmd.emit_tok) begin
        emit_idx_r <= emit_idx_r + LEN_W'(1);
        out_valid_r <= 1'b1;
      end else if (cmd.emit_tail) begin
        out_valid_r <= 1'b1;
        if (cur_end_r) begin
          hits_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `WWTR_ASSERT_IMP(a_ovf_empty, tok_ovf_r, tok_cnt_r == '0, "overflowed token holds bytes")
  `WWTR_ASSERT_IMP(a_emit_range, cmd.emit_tok, emit_idx_r < emit_len_r, "emit past length")
  `WWTR_ASSERT_NXT(a_end_clears, cmd.emit_tail && cur_end_r, hits_r == '0, "hits not cleared")
  `WWTR_ASSERT_IMP(a_last_empty, out_valid_r && out_r.last, !out_r.byte_valid,
                   "last result carries a byte")

endmodule
